[hdl/sptt_pkg.sv]
// ----------------------------------------------------------------------------
// sptt_pkg
// Shared types and codes for the sorted priority task table.
// ----------------------------------------------------------------------------
package sptt_pkg;

  localparam int unsigned TAG_W  = 64;
  localparam int unsigned PRIO_W = 8;
  localparam int unsigned FUNC_W = 2;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned IN_W   = 80;
  localparam int unsigned OUT_W  = 80;

  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

  localparam logic [STAT_W-1:0] STAT_DONE = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NONE = 2'd2;

  typedef struct packed {
    logic capture;
    logic apply;
  } sptt_cmd_t;

  typedef struct packed {
    logic out_free;
  } sptt_sts_t;

endpackage

[hdl/sptt_ctrl.sv]
// ----------------------------------------------------------------------------
// sptt_ctrl
// Sequencer: captures a request, then applies it once the result slot is free.
// ----------------------------------------------------------------------------
module sptt_ctrl
  import sptt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      req_valid_i,
  output logic      req_ready_o,
  input  sptt_sts_t sts_i,
  output sptt_cmd_t cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_APPLY
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d       = state_q;
    req_ready_o   = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.apply   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        req_ready_o   = 1'b1;
        cmd_o.capture = req_valid_i;
        if (req_valid_i) begin
          state_d = ST_APPLY;
        end
      end
      ST_APPLY: begin
        cmd_o.apply = sts_i.out_free;
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[hdl/sptt_dp.sv]
// ----------------------------------------------------------------------------
// sptt_dp
// Row of table cells with per-cell compares, neighbor shifts and result register.
// ----------------------------------------------------------------------------
module sptt_dp
  import sptt_pkg::*;
#(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned NAME_BITS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sptt_cmd_t         cmd_i,
  output sptt_sts_t         sts_o,
  input  logic [FUNC_W-1:0] func_i,
  input  logic [TAG_W-1:0]  name_tag_i,
  input  logic [PRIO_W-1:0] prio_i,
  input  logic              completed_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [STAT_W-1:0] status_o,
  output logic [TAG_W-1:0]  found_name_o,
  output logic [PRIO_W-1:0] found_prio_o
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [NAME_BITS-1:0] cell_name_q [DEPTH];
  logic [PRIO_W-1:0]    cell_prio_q [DEPTH];
  logic                 cell_done_q [DEPTH];
  logic [CNT_W-1:0]     count_q;

  logic [FUNC_W-1:0]    func_q;
  logic [NAME_BITS-1:0] new_name_q;
  logic [PRIO_W-1:0]    new_prio_q;
  logic                 new_done_q;
  logic [DEPTH-1:0]     ge_q, hit_q, open_q;

  logic [NAME_BITS-1:0] in_name;
  logic [DEPTH-1:0]     hit_incl, first_open;
  logic                 full, any_hit, any_open, ins_en, rem_en;
  logic [NAME_BITS-1:0] sel_name;
  logic [PRIO_W-1:0]    sel_prio;

  logic                 out_valid_q;
  logic [STAT_W-1:0]    status_q;
  logic [TAG_W-1:0]     found_name_q;
  logic [PRIO_W-1:0]    found_prio_q;

  assign in_name = name_tag_i[NAME_BITS-1:0];

  // per-cell compares at capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q     <= func_i;
      new_name_q <= in_name;
      new_prio_q <= prio_i;
      new_done_q <= completed_i;
      for (int i = 0; i < DEPTH; i++) begin
        if (count_q > CNT_W'(i)) begin
          ge_q[i]   <= (prio_i > cell_prio_q[i]) ||
                       ((prio_i == cell_prio_q[i]) && completed_i);
          hit_q[i]  <= (cell_name_q[i] == in_name);
          open_q[i] <= !cell_done_q[i];
        end else begin
          ge_q[i]   <= 1'b0;
          hit_q[i]  <= 1'b0;
          open_q[i] <= 1'b0;
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      hit_incl[i]   = |(hit_q & ({DEPTH{1'b1}} >> (DEPTH - 1 - i)));
      first_open[i] = open_q[i] & ~(|(open_q & ~({DEPTH{1'b1}} << i)));
    end
    sel_name = '0;
    sel_prio = '0;
    for (int i = 0; i < DEPTH; i++) begin
      sel_name = sel_name | ({NAME_BITS{first_open[i]}} & cell_name_q[i]);
      sel_prio = sel_prio | ({PRIO_W{first_open[i]}} & cell_prio_q[i]);
    end
  end

  assign full     = (count_q == CNT_W'(DEPTH));
  assign any_hit  = |hit_q;
  assign any_open = |open_q;
  assign ins_en   = cmd_i.apply && (func_q == FUNC_INSERT) && !full;
  assign rem_en   = cmd_i.apply && (func_q == FUNC_REMOVE) && any_hit;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic                 prev_ge;
    logic [NAME_BITS-1:0] prev_name, next_name;
    logic [PRIO_W-1:0]    prev_prio, next_prio;
    logic                 prev_done, next_done;

    if (g == 0) begin : g_first
      assign prev_ge   = 1'b0;
      assign prev_name = cell_name_q[g];
      assign prev_prio = cell_prio_q[g];
      assign prev_done = cell_done_q[g];
    end else begin : g_mid
      assign prev_ge   = ge_q[g-1];
      assign prev_name = cell_name_q[g-1];
      assign prev_prio = cell_prio_q[g-1];
      assign prev_done = cell_done_q[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign next_name = cell_name_q[g];
      assign next_prio = cell_prio_q[g];
      assign next_done = cell_done_q[g];
    end else begin : g_body
      assign next_name = cell_name_q[g+1];
      assign next_prio = cell_prio_q[g+1];
      assign next_done = cell_done_q[g+1];
    end

    always_ff @(posedge clk_i) begin
      if (ins_en) begin
        if (prev_ge) begin
          cell_name_q[g] <= prev_name;
          cell_prio_q[g] <= prev_prio;
          cell_done_q[g] <= prev_done;
        end else if (ge_q[g] || (count_q == CNT_W'(g))) begin
          cell_name_q[g] <= new_name_q;
          cell_prio_q[g] <= new_prio_q;
          cell_done_q[g] <= new_done_q;
        end
      end else if (rem_en && hit_incl[g]) begin
        cell_name_q[g] <= next_name;
        cell_prio_q[g] <= next_prio;
        cell_done_q[g] <= next_done;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (ins_en) begin
      count_q <= count_q + CNT_W'(1);
    end else if (rem_en) begin
      count_q <= count_q - CNT_W'(1);
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.apply) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.apply) begin
      found_name_q <= '0;
      found_prio_q <= '0;
      case (func_q)
        FUNC_INSERT: status_q <= full ? STAT_FULL : STAT_DONE;
        FUNC_REMOVE: status_q <= any_hit ? STAT_DONE : STAT_NONE;
        FUNC_QUERY: begin
          if (any_open) begin
            status_q     <= STAT_DONE;
            found_name_q <= TAG_W'(sel_name);
            found_prio_q <= sel_prio;
          end else begin
            status_q <= STAT_NONE;
          end
        end
        default: status_q <= STAT_NONE;
      endcase
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign found_name_o   = found_name_q;
  assign found_prio_o   = found_prio_q;

endmodule

[hdl/sorted_priority_task_table.sv]
// ----------------------------------------------------------------------------
// sorted_priority_task_table
// Task table kept in descending priority order: insert, remove by name, query.
// ----------------------------------------------------------------------------
// Channel  Dir  Bus             Contents
// s_axis   in   tuser[1:0]      func
//               tdata[79:0]     name_tag, prio, completed
// m_axis   out  tdata[79:0]     status, found_name, found_prio
//
// A request is first captured with per-cell compares, then applied: the
// apply shifts the cell row and loads the result register.
// The apply waits while an earlier result is still held on m_axis.
// Reset empties the table at once; entry contents need no clearing.
// ----------------------------------------------------------------------------
module sorted_priority_task_table
  import sptt_pkg::*;
#(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned NAME_BITS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // [63:0] name_tag, [71:64] prio, [72] completed, rest zero
  input  logic [IN_W-1:0]   s_axis_tdata_i,
  // [1:0] func
  input  logic [FUNC_W-1:0] s_axis_tuser_i,
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  // [1:0] status, [65:2] found_name, [73:66] found_prio, rest zero
  output logic [OUT_W-1:0]  m_axis_tdata_o
);

  sptt_cmd_t         cmd;
  sptt_sts_t         sts;
  logic [STAT_W-1:0] status;
  logic [TAG_W-1:0]  found_name;
  logic [PRIO_W-1:0] found_prio;

  sptt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid_i),
    .req_ready_o (s_axis_tready_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sptt_dp #(
    .DEPTH     (DEPTH),
    .NAME_BITS (NAME_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .func_i       (s_axis_tuser_i),
    .name_tag_i   (s_axis_tdata_i[63:0]),
    .prio_i       (s_axis_tdata_i[71:64]),
    .completed_i  (s_axis_tdata_i[72]),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .status_o     (status),
    .found_name_o (found_name),
    .found_prio_o (found_prio)
  );

  assign m_axis_tdata_o = {6'd0, found_prio, found_name, status};

endmodule

[tb/tb_sorted_priority_task_table.sv]
// ----------------------------------------------------------------------------
// tb_sorted_priority_task_table
// Self-checking bench for the sorted task table. A scoreboard keeps its own
// copy of the table, predicts one reply per accepted request and compares
// each reply field by field. Directed corner requests come first, then
// random insert/remove/query/no-op traffic with random stalls on both streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_sorted_priority_task_table;
  import sptt_pkg::*;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned IDLE_LIMIT = 3000;
  localparam int unsigned RAND_ITEMS = 440;

  localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [TAG_W-1:0]  tag;
    logic [PRIO_W-1:0] prio;
  } reply_t;

  class task_table_scoreboard;
    logic [TAG_W-1:0]  tags[DEPTH];
    logic [PRIO_W-1:0] prios[DEPTH];
    bit                done_flags[DEPTH];
    int unsigned       fill;
    reply_t            replies[$];
    int unsigned       mismatches;

    function new();
      fill       = 0;
      mismatches = 0;
    endfunction

    function void flag(string what, logic [79:0] exp_val, logic [79:0] act_val);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch: expected %h, got %h", $time, what, exp_val, act_val);
    endfunction

    function void note_request(logic [FUNC_W-1:0] func, logic [TAG_W-1:0] tag,
                               logic [PRIO_W-1:0] prio, bit done);
      reply_t r;
      int     pos;
      int     i;
      bit     hit;
      r   = '0;
      hit = 0;
      case (func)
        FUNC_INSERT: begin
          if (fill >= DEPTH) begin
            r.status = STAT_FULL;
          end else begin
            pos = fill;
            for (i = 0; i < fill; i++) begin
              if (!hit && (prio > prios[i] || (prio == prios[i] && done))) begin
                pos = i;
                hit = 1;
              end
            end
            for (i = fill; i > pos; i--) begin
              tags[i]       = tags[i-1];
              prios[i]      = prios[i-1];
              done_flags[i] = done_flags[i-1];
            end
            tags[pos]       = tag;
            prios[pos]      = prio;
            done_flags[pos] = done;
            fill++;
            r.status = STAT_DONE;
          end
        end
        FUNC_REMOVE: begin
          r.status = STAT_NONE;
          for (i = 0; i < fill; i++) begin
            if (!hit && tags[i] == tag) begin
              hit = 1;
              pos = i;
            end
          end
          if (hit) begin
            for (i = pos; i + 1 < fill; i++) begin
              tags[i]       = tags[i+1];
              prios[i]      = prios[i+1];
              done_flags[i] = done_flags[i+1];
            end
            fill--;
            r.status = STAT_DONE;
          end
        end
        FUNC_QUERY: begin
          r.status = STAT_NONE;
          for (i = 0; i < fill; i++) begin
            if (!hit && !done_flags[i]) begin
              hit      = 1;
              r.status = STAT_DONE;
              r.tag    = tags[i];
              r.prio   = prios[i];
            end
          end
        end
        default: begin
          r.status = STAT_NONE;
        end
      endcase
      replies.push_back(r);
    endfunction

    function void check_reply(logic [OUT_W-1:0] bus);
      reply_t exp_r;
      if (replies.size() == 0) begin
        flag("unrequested reply", '0, bus);
        return;
      end
      exp_r = replies.pop_front();
      if (bus[1:0] !== exp_r.status)
        flag("status", exp_r.status, bus[1:0]);
      if (bus[65:2] !== exp_r.tag)
        flag("found_name", exp_r.tag, bus[65:2]);
      if (bus[73:66] !== exp_r.prio)
        flag("found_prio", exp_r.prio, bus[73:66]);
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid_i;
  logic              s_axis_tready_o;
  logic [IN_W-1:0]   s_axis_tdata_i;
  logic [FUNC_W-1:0] s_axis_tuser_i;
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i;
  logic [OUT_W-1:0]  m_axis_tdata_o;

  task_table_scoreboard table_sb;
  bit          src_idle_on;
  bit          sink_idle_on;
  int unsigned sink_hold_cycles;
  int unsigned idle_cycles;

  sorted_priority_task_table #(
    .DEPTH    (DEPTH),
    .NAME_BITS(TAG_W)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(logic [FUNC_W-1:0] func, logic [TAG_W-1:0] tag,
                              logic [PRIO_W-1:0] prio, bit done);
    int gap;
    gap = src_idle_on ? $urandom_range(0, 13) : 0;
    repeat (gap) begin
      s_axis_tvalid_i = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tuser_i  = func;
    s_axis_tdata_i  = {7'b0, done, prio, tag};
    do @(posedge clk_i); while (!s_axis_tready_o);
    table_sb.note_request(func, tag, prio, done);
    @(negedge clk_i);
  endtask

  task automatic drain_replies();
    s_axis_tvalid_i = 1'b0;
    while (table_sb.replies.size() != 0) @(negedge clk_i);
  endtask

  task automatic send_random_request(bit fill_bias);
    logic [FUNC_W-1:0] func;
    logic [TAG_W-1:0]  tag;
    logic [PRIO_W-1:0] prio;
    int                pick;
    int                sel;
    pick = $urandom_range(0, 99);
    if (pick < 4)
      func = FUNC_NOP;
    else if (pick < (fill_bias ? 64 : 34))
      func = FUNC_INSERT;
    else if (pick < (fill_bias ? 80 : 74))
      func = FUNC_REMOVE;
    else
      func = FUNC_QUERY;
    tag = {$urandom, $urandom};
    if (table_sb.fill > 0 && $urandom_range(0, 3) != 0)
      tag = table_sb.tags[$urandom_range(0, table_sb.fill - 1)];
    sel = $urandom_range(0, 9);
    if (table_sb.fill > 0 && sel < 4)
      prio = table_sb.prios[$urandom_range(0, table_sb.fill - 1)];
    else if (sel == 4)
      prio = 8'h00;
    else if (sel == 5)
      prio = 8'hff;
    else
      prio = PRIO_W'($urandom_range(0, 255));
    send_request(func, tag, prio, 1'($urandom_range(0, 1)));
  endtask

  initial begin
    bit held;
    held            = 1'b0;
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (sink_hold_cycles > 0 && !held) begin
        m_axis_tready_i = 1'b0;
        repeat (sink_hold_cycles) @(negedge clk_i);
        held = 1'b1;
      end
      repeat (sink_idle_on ? $urandom_range(0, 13) : 0) begin
        m_axis_tready_i = 1'b0;
        @(negedge clk_i);
      end
      m_axis_tready_i = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      table_sb.check_reply(m_axis_tdata_o);
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("sorted_priority_task_table verification failed");
        $finish;
      end
    end else begin
      idle_cycles <= 0;
    end
  end

  initial begin
    int i;
    table_sb         = new();
    rst_ni           = 1'b0;
    s_axis_tvalid_i  = 1'b0;
    s_axis_tdata_i   = '0;
    s_axis_tuser_i   = '0;
    src_idle_on      = 1'b1;
    sink_idle_on     = 1'b1;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // empty table, no-op func, tie ordering, extremes, duplicates, full table
    send_request(FUNC_QUERY, 64'h0, 8'h00, 1'b0);
    send_request(FUNC_REMOVE, 64'h1234_5678_9abc_def0, 8'h00, 1'b0);
    send_request(FUNC_NOP, 64'hffff_ffff_ffff_ffff, 8'hff, 1'b1);
    send_request(FUNC_INSERT, 64'h4141_4141_4141_4141, 8'd100, 1'b0);
    send_request(FUNC_INSERT, 64'h4242_4242_4242_4242, 8'd100, 1'b1);
    send_request(FUNC_INSERT, 64'h4343_4343_4343_4343, 8'd100, 1'b0);
    send_request(FUNC_INSERT, 64'hffff_ffff_ffff_ffff, 8'hff, 1'b0);
    send_request(FUNC_INSERT, 64'h0, 8'h00, 1'b1);
    send_request(FUNC_QUERY, 64'h0, 8'h00, 1'b0);
    send_request(FUNC_INSERT, 64'h4141_4141_4141_4141, 8'd5, 1'b0);
    send_request(FUNC_REMOVE, 64'h4141_4141_4141_4141, 8'h00, 1'b0);
    send_request(FUNC_REMOVE, 64'hffff_ffff_ffff_ffff, 8'h00, 1'b0);
    send_request(FUNC_QUERY, 64'h0, 8'h00, 1'b0);
    send_request(FUNC_REMOVE, 64'h5a5a_5a5a_5a5a_5a5a, 8'h00, 1'b0);
    for (i = 0; i < 11; i++)
      send_request(FUNC_INSERT, {$urandom, $urandom}, PRIO_W'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)));
    send_request(FUNC_INSERT, 64'h7777_7777_7777_7777, 8'hff, 1'b1);

    // sink stalls long while the source keeps pushing
    drain_replies();
    src_idle_on      = 1'b0;
    sink_hold_cycles = 300;
    for (i = 0; i < 30; i++)
      send_random_request(1'b0);
    drain_replies();
    src_idle_on = 1'b1;

    for (i = 0; i < RAND_ITEMS; i++) begin
      if (i % 60 == 0) begin
        src_idle_on  = $urandom_range(0, 2) != 0;
        sink_idle_on = $urandom_range(0, 2) != 0;
      end
      if (i == RAND_ITEMS / 2)
        drain_replies();
      send_random_request((i / 50) % 2 == 0);
    end

    drain_replies();
    repeat (20) @(posedge clk_i);
    if (table_sb.mismatches == 0 && table_sb.replies.size() == 0)
      $display("sorted_priority_task_table verification clean");
    else
      $display("sorted_priority_task_table verification failed");
    $finish;
  end

endmodule
